@@ rtl/sssc_pkg.sv @@
// ----------------------------------------------------------------------------
// sssc_pkg
// Shared types, constants and fixed-point helpers for the selective scan core.
// ----------------------------------------------------------------------------
package sssc_pkg;

  localparam int unsigned LOG2E_Q16 = 94548;

  typedef enum logic [0:0] {
    CFG_SKIP_GAIN   = 1'b0,
    CFG_SKIP_ENABLE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic        [30:0] step_size;
    logic signed [31:0] decay_rate;
    logic signed [31:0] in_gain;
    logic signed [31:0] out_gain;
    logic        [5:0]  position;
    logic        [3:0]  state_index;
    logic               first_step;
    logic               last_state;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic        [5:0]  out_position;
  } out_item_t;

  typedef struct packed {
    logic        [0:0]  index;
    logic        [31:0] data;
  } cfg_item_t;

  // 2^(i/16) in Q16.16
  function automatic logic [17:0] pow2_frac(input logic [4:0] i);
    logic [17:0] v;
    begin
      case (i)
        5'd0:  v = 18'd65536;
        5'd1:  v = 18'd68438;
        5'd2:  v = 18'd71468;
        5'd3:  v = 18'd74632;
        5'd4:  v = 18'd77936;
        5'd5:  v = 18'd81386;
        5'd6:  v = 18'd84990;
        5'd7:  v = 18'd88752;
        5'd8:  v = 18'd92682;
        5'd9:  v = 18'd96785;
        5'd10: v = 18'd101070;
        5'd11: v = 18'd105545;
        5'd12: v = 18'd110218;
        5'd13: v = 18'd115098;
        5'd14: v = 18'd120194;
        5'd15: v = 18'd125515;
        default: v = 18'd131072;
      endcase
      return v;
    end
  endfunction

  // saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    begin
      if (v > 64'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
    end
  endfunction

  // product >>> 16 (floor) then saturate
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [63:0] s;
    begin
      s = p >>> 16;
      return sat32(s);
    end
  endfunction

endpackage

@@ rtl/sssc_stream_if.sv @@
// ----------------------------------------------------------------------------
// sssc_stream_if
// Valid/ready channel carrying one item of a generic payload type.
// ----------------------------------------------------------------------------
interface sssc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sssc_ram.sv @@
// ----------------------------------------------------------------------------
// sssc_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/selective_state_space_scan_core.sv @@
// ----------------------------------------------------------------------------
// selective_state_space_scan_core
// One-head selective state-space scan, one term per item, state in a RAM.
// ----------------------------------------------------------------------------
// channel | dir | payload                                  | accept
// in      | in  | x, dt, A, B, C, position, state, flags   | in_valid & in_ready
// out     | out | y_value, out_position                    | out_valid & out_ready
// cfg     | in  | index (0 skip_gain, 1 skip_enable), data | cfg_valid & cfg_ready
//
// An item passes through these steps from its accept to the next accept:
// dt*A with the state RAM read, exp scaling and B*x, exp mantissa and h+u,
// a*(h+u), C*h accumulate, write-back and skip multiply, then idle. A
// last_state item adds an output-load step that loads its result.
// A result waits in the output register while the next item is already taken.
// Reset (synchronous) clears control and the accumulator; the state RAM is not
// cleared. A stalled output holds the sequencer only at its final step.
module selective_state_space_scan_core
  import sssc_pkg::*;
#(
  parameter int NUM_POS = 64,
  parameter int D_STATE = 16
) (
  input  logic clk,
  input  logic rst_n,
  sssc_stream_if.sink   in_ch,
  sssc_stream_if.source out_ch,
  sssc_stream_if.sink   cfg_ch
);
  localparam int DEPTH = NUM_POS * D_STATE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EXP0, S_EXP1, S_EXP2, S_UPD, S_ACC, S_OUT
  } state_t;

  state_t             state_r;
  in_item_t           item_r;
  logic               inr_r;
  logic [AW-1:0]      addr_r;
  logic signed [31:0] z_r, a_r, u_r, h_r, acc_r, skip_gain_r;
  logic signed [63:0] w_r;
  logic               skip_en_r;
  logic               ovalid_r;
  out_item_t          odata_r;
  logic signed [31:0] rdata;
  logic               we;
  logic               out_load;

  sssc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr(addr_r), .wdata(h_r), .raddr(addr_r), .rdata
  );

  assign we           = (state_r == S_ACC) && inr_r;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;
  assign out_load     = (state_r == S_OUT) && (!ovalid_r || out_ch.ready);

  // exp mantissa pieces
  logic signed [63:0] n_w;
  logic [15:0]        f_w;
  logic [17:0]        lo_w, hi_w, mant_w;
  logic [29:0]        dif_w;
  logic signed [31:0] exp_w;
  logic signed [63:0] shl_w;
  logic [5:0]         sh_w;

  always_comb begin
    n_w    = w_r >>> 16;
    f_w    = w_r[15:0];
    lo_w   = pow2_frac({1'b0, f_w[15:12]});
    hi_w   = pow2_frac({1'b0, f_w[15:12]} + 5'd1);
    dif_w  = 30'(hi_w - lo_w) * 30'(f_w[11:0]);
    mant_w = lo_w + 18'(dif_w >> 12);
    shl_w  = 64'({46'd0, mant_w}) << n_w[3:0];
    sh_w   = (n_w < -64'sd31) ? 6'd31 : 6'(-n_w);
    if (n_w > 64'sd14)        exp_w = 32'sh7FFFFFFF;
    else if (n_w >= 64'sd0)   exp_w = sat32(shl_w);
    else                      exp_w = 32'({14'd0, mant_w} >> sh_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      ovalid_r    <= 1'b0;
      skip_gain_r <= '0;
      skip_en_r   <= 1'b0;
    end else begin
      if (out_load) ovalid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      if (cfg_ch.valid) begin
        case (cfg_ch.data.index)
          CFG_SKIP_GAIN:   skip_gain_r <= cfg_ch.data.data;
          CFG_SKIP_ENABLE: skip_en_r   <= cfg_ch.data.data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          item_r  <= in_ch.data;
          inr_r   <= (32'(in_ch.data.position) < NUM_POS) &&
                     (32'(in_ch.data.state_index) < D_STATE);
          addr_r  <= AW'(32'(in_ch.data.position) * D_STATE +
                         32'(in_ch.data.state_index));
          state_r <= S_RD;
        end
        S_RD: begin
          z_r     <= qsat($signed({33'd0, item_r.step_size}) *
                          64'(item_r.decay_rate));
          state_r <= S_EXP0;
        end
        S_EXP0: begin
          w_r     <= (64'(z_r) * $signed(64'(LOG2E_Q16))) >>> 16;
          u_r     <= qsat(64'(item_r.in_gain) * 64'(item_r.x_value));
          state_r <= S_EXP1;
        end
        S_EXP1: begin
          a_r     <= exp_w;
          h_r     <= sat32(64'((item_r.first_step || !inr_r) ? 32'sd0 : rdata)
                           + 64'(u_r));
          state_r <= S_EXP2;
        end
        S_EXP2: begin
          h_r     <= qsat(64'(a_r) * 64'(h_r));
          state_r <= S_UPD;
        end
        S_UPD: begin
          acc_r   <= sat32(64'(acc_r) + 64'(qsat(64'(item_r.out_gain) * 64'(h_r))));
          state_r <= S_ACC;
        end
        S_ACC: begin
          u_r     <= qsat(64'(skip_gain_r) * 64'(item_r.x_value));
          state_r <= item_r.last_state ? S_OUT : S_IDLE;
        end
        S_OUT: if (out_load) begin
          odata_r.y_value      <= skip_en_r ? sat32(64'(acc_r) + 64'(u_r)) : acc_r;
          odata_r.out_position <= item_r.position;
          acc_r                <= '0;
          state_r              <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/sssc_checker.sv @@
// ----------------------------------------------------------------------------
// sssc_checker
// Port-level checks on the scan core, bound to the top level.
// ----------------------------------------------------------------------------
module sssc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [37:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item dropped or changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##5 !in_ready)
    else $error("item finished too early");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind selective_state_space_scan_core sssc_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the selective scan core: directed table of terms, then random
// sequences, each result compared against a cycle-free model of the scan.
// ----------------------------------------------------------------------------
module testbench;
  import sssc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HD = 64;
  localparam int DS = 16;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  sssc_stream_if #(.T(in_item_t))  in_ch ();
  sssc_stream_if #(.T(out_item_t)) out_ch ();
  sssc_stream_if #(.T(cfg_item_t)) cfg_ch ();

  selective_state_space_scan_core #(.NUM_POS(HD), .D_STATE(DS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // model state
  logic signed [31:0] m_h [HD*DS];
  logic signed [31:0] m_acc;
  logic signed [31:0] m_skip_gain;
  logic               m_skip_en;
  bit                 written [HD*DS];

  out_item_t y_queue[$];
  int errors = 0, n_results = 0, n_items = 0, idle = 0;
  int rx_wait = 0, hold_cnt = 0;
  bit hold_req = 0, rx_taken = 0;

  function automatic logic signed [63:0] fshr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] sat(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qm(logic signed [63:0] a, logic signed [63:0] b);
    return sat(fshr(a * b, 16));
  endfunction

  function automatic logic signed [63:0] mant_tab(int i);
    int t[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
                  96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
    return t[i];
  endfunction

  function automatic logic signed [31:0] exp_q16(logic signed [31:0] z);
    logic signed [63:0] w, n, lo, hi, mant;
    int f, sh;
    w = fshr(64'(z) * 64'sd94548, 16);
    n = fshr(w, 16);
    f = int'(w[15:0]);
    lo = mant_tab(f >> 12);
    hi = mant_tab((f >> 12) + 1);
    mant = lo + (((hi - lo) * (f & 12'hFFF)) >>> 12);
    if (n > 14) return 32'sh7FFFFFFF;
    if (n >= 0) return sat(mant << n);
    sh = (-n > 31) ? 31 : int'(-n);
    return 32'(mant >>> sh);
  endfunction

  // advance the model by one term; queue a result on last_state
  function automatic void scan_term(in_item_t t);
    int slot;
    logic signed [31:0] prev, a, u, h;
    out_item_t r;
    slot = int'(t.position) * DS + int'(t.state_index);
    prev = t.first_step ? 32'sd0 : m_h[slot];
    a = exp_q16(qm(64'(t.step_size), 64'(t.decay_rate)));
    u = qm(64'(t.in_gain), 64'(t.x_value));
    h = qm(64'(a), 64'(sat(64'(prev) + 64'(u))));
    m_h[slot] = h;
    written[slot] = 1;
    m_acc = sat(64'(m_acc) + 64'(qm(64'(t.out_gain), 64'(h))));
    if (t.last_state) begin
      r.y_value = m_acc;
      if (m_skip_en) r.y_value = sat(64'(m_acc) + 64'(qm(64'(m_skip_gain), 64'(t.x_value))));
      r.out_position = t.position;
      y_queue.push_back(r);
      m_acc = 0;
    end
  endfunction

  initial begin
    in_ch.valid = 0; in_ch.data = '0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
    out_ch.ready = 0;
    m_acc = 0; m_skip_gain = 0; m_skip_en = 0;
    foreach (m_h[i]) begin m_h[i] = 0; written[i] = 0; end
  end

  // sink side: a drawn wait before each item, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = $urandom_range(0, 18);
    end else begin
      if (hold_req) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (rx_taken) rx_wait = $urandom_range(0, 18);
      rx_taken = 1'b0;
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      out_item_t e;
      n_results++;
      rx_taken = 1'b1;
      if (y_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result y=%0d pos=%0d",
                                   out_ch.data.y_value, out_ch.data.out_position);
      end else begin
        e = y_queue.pop_front();
        if (e !== out_ch.data) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp y=%0d pos=%0d got y=%0d pos=%0d", e.y_value,
                     e.out_position, out_ch.data.y_value, out_ch.data.out_position);
        end
      end
    end
  end

  // watchdog on accepted items
  always @(posedge clk) begin
    if (!rst_n) idle <= 0;
    else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
             (cfg_ch.valid && cfg_ch.ready)) idle <= 0;
    else idle <= idle + 1;
    if (idle >= WATCHDOG) begin
      $display("watchdog: no progress, %0d results still expected", y_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_SKIP_GAIN) m_skip_gain = val;
    else m_skip_en = val[0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (y_queue.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // send one term; valid stays high if the next one follows with no gap
  task automatic send_term(in_item_t t, bit check_fixed, out_item_t fixed_r);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 5) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.data <= t;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    scan_term(t);
    if (check_fixed && t.last_state && y_queue[$] !== fixed_r) begin
      errors++;
      if (errors <= 10) $display("directed row: model gives y=%0d, table %0d",
                                 y_queue[$].y_value, fixed_r.y_value);
    end
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_val(int kind);
    case ($urandom_range(0, kind))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'h00010000;
      4: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      default: return $urandom;
    endcase
  endfunction

  in_item_t row;
  out_item_t ok;
  int seq_pos, ns, p;

  function automatic in_item_t mk(logic [31:0] x, logic [30:0] dt, logic [31:0] a,
      logic [31:0] b, logic [31:0] c, int pos, int s, bit f, bit l);
    in_item_t t;
    t.x_value = x; t.step_size = dt; t.decay_rate = a; t.in_gain = b; t.out_gain = c;
    t.position = 6'(pos); t.state_index = 4'(s); t.first_step = f; t.last_state = l;
    return t;
  endfunction

  initial begin
    in_item_t tbl[$];
    out_item_t tres[$];
    bit tchk[$];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table: zero dt gives a=1, so y = C*B*x readable directly
    tbl.push_back(mk(32'h00010000, 0, 0, 32'h00010000, 32'h00010000, 0, 0, 1, 1));
    tres.push_back('{32'h00010000, 6'd0}); tchk.push_back(1);
    tbl.push_back(mk(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 63, 15, 1, 1));
    tres.push_back('{32'h7FFFFFFF, 6'd63}); tchk.push_back(1);
    tbl.push_back(mk(32'h80000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0, 1, 1));
    tres.push_back('{32'h80000000, 6'd1}); tchk.push_back(1);
    tbl.push_back(mk(32'h80000000, 0, 0, 32'h80000000, 32'h7FFFFFFF, 2, 0, 1, 1));
    tres.push_back('{32'h7FFFFFFF, 6'd2}); tchk.push_back(1);
    // large positive exponent saturates, large negative vanishes
    tbl.push_back(mk(32'h00010000, 31'h7FFFFFFF, 32'h7FFFFFFF, 32'h00010000,
                     32'h00010000, 3, 0, 1, 1));
    tres.push_back('{32'h7FFFFFFF, 6'd3}); tchk.push_back(1);
    tbl.push_back(mk(32'h00010000, 31'h7FFFFFFF, 32'h80000000, 32'h00010000,
                     32'h00010000, 4, 0, 1, 1));
    tres.push_back('{32'h0, 6'd4}); tchk.push_back(1);
    // accumulate across states into one output, then reuse stored state
    for (int s = 0; s < 4; s++) begin
      tbl.push_back(mk(32'h00020000, 31'h00008000, 32'hFFFF0000, 32'h00018000,
                       32'hFFFF8000, 5, s, 1, s == 3));
      tres.push_back('0); tchk.push_back(0);
    end
    for (int s = 0; s < 4; s++) begin
      tbl.push_back(mk(32'hFFFE8000, 31'h00004000, 32'h00010000, 32'h00010000,
                       32'h00008000, 5, s, 0, s == 3));
      tres.push_back('0); tchk.push_back(0);
    end
    tbl.push_back(mk(32'h12345678, 31'h00001234, 32'hFEDCBA98, 32'h0000FFFF,
                     32'h00030000, 6, 15, 1, 1));
    tres.push_back('0); tchk.push_back(0);
    foreach (tbl[i]) send_term(tbl[i], tchk[i], tres[i]);
    idle_input();
    wait_idle();

    // random part over several skip settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_SKIP_GAIN, 32'h00010000); write_reg(CFG_SKIP_ENABLE, 1); end
        1: write_reg(CFG_SKIP_GAIN, 32'h7FFFFFFF);
        2: write_reg(CFG_SKIP_GAIN, 32'h80000000);
        3: write_reg(CFG_SKIP_ENABLE, 0);
        4: begin write_reg(CFG_SKIP_GAIN, $urandom); write_reg(CFG_SKIP_ENABLE, 1); end
        default: write_reg(CFG_SKIP_GAIN, 32'hFFFFFFFF);
      endcase
      if (phase == 2) hold_req = 1;
      for (int k = 0; k < 115; ) begin
        p = $urandom_range(0, 63);
        ns = $urandom_range(0, 15) == 0 ? 16 : $urandom_range(1, 4);
        for (int s = 0; s < ns; s++) begin
          row.x_value = rnd_val(8);
          row.step_size = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h30000));
          row.decay_rate = ($urandom_range(0, 7) == 0) ? rnd_val(8)
                           : -$signed(32'($urandom_range(0, 32'h40000)));
          row.in_gain = rnd_val(8);
          row.out_gain = rnd_val(8);
          row.position = 6'(p);
          row.state_index = 4'(s);
          // first_step where the slot was never written, so no undefined read
          row.first_step = !written[p*DS+s] || ($urandom_range(0, 5) == 0);
          row.last_state = (s == ns - 1) || ($urandom_range(0, 19) == 0);
          if ($urandom_range(0, 9) == 0) begin
            row.state_index = 4'($urandom_range(0, 15));
            row.first_step = !written[p*DS+row.state_index] || $urandom_range(0, 1);
          end
          send_term(row, 0, '0);
          k++;
        end
      end
      idle_input();
      wait_idle();
    end

    $display("Covered %0d terms, %0d results, skip gain extremes and long output stall.",
             n_items, n_results);
    if (errors == 0 && y_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, y_queue.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
